// ===== hdl/y2r_pkg.sv =====
// ----------------------------------------------------------------------------
// y2r_pkg: shared types and helpers of the YUV 4:2:0 to RGB24 block
// Fixed-point BT.601 studio-range weights, payload structs, clamp and
// saturation helpers.
// ----------------------------------------------------------------------------
package y2r_pkg;

  localparam int SAMPLE_W    = 8;
  localparam int LUMA_TERM_W = 17;  // 298 * 224 fits in 17 bits
  localparam int SUM_W       = 19;  // signed luma + chroma sum

  localparam int LUMA_GAIN    = 298;
  localparam int RED_FROM_V   = 408;
  localparam int GREEN_FROM_U = 100;
  localparam int GREEN_FROM_V = 208;
  localparam int BLUE_FROM_U  = 517;
  localparam int LEVEL_LOW    = 16;
  localparam int LEVEL_HIGH   = 240;
  localparam int CHROMA_ZERO  = 128;
  localparam int SUM_LIMIT    = 'h10000;
  localparam int BYTE_MASK    = 'hff;
  localparam int FRAC_BITS    = 8;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  typedef struct packed {
    sample_t luma_top_left;
    sample_t luma_top_right;
    sample_t luma_bottom_left;
    sample_t luma_bottom_right;
    sample_t chroma_blue;
    sample_t chroma_red;
  } in_item_t;

  typedef struct packed {
    sample_t red_top_left;
    sample_t green_top_left;
    sample_t blue_top_left;
    sample_t red_top_right;
    sample_t green_top_right;
    sample_t blue_top_right;
    sample_t red_bottom_left;
    sample_t green_bottom_left;
    sample_t blue_bottom_left;
    sample_t red_bottom_right;
    sample_t green_bottom_right;
    sample_t blue_bottom_right;
  } out_item_t;

  // Chroma contributions shared by the four pixels of a block
  typedef struct packed {
    sum_t red;
    sum_t green;
    sum_t blue;
  } chroma_terms_t;

  typedef struct packed {
    sample_t red;
    sample_t green;
    sample_t blue;
  } rgb_t;

  function automatic sample_t clamp_level(sample_t v);
    sample_t r;
    if (v < SAMPLE_W'(LEVEL_LOW)) begin
      r = SAMPLE_W'(LEVEL_LOW);
    end else if (v > SAMPLE_W'(LEVEL_HIGH)) begin
      r = SAMPLE_W'(LEVEL_HIGH);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Truncate the fraction, then saturate to one byte
  function automatic sample_t saturate_byte(sum_t s);
    sample_t r;
    if (s[SUM_W-1]) begin
      r = '0;
    end else if (s >= SUM_W'(SUM_LIMIT)) begin
      r = SAMPLE_W'(BYTE_MASK);
    end else begin
      r = s[FRAC_BITS +: SAMPLE_W];
    end
    return r;
  endfunction

endpackage

// ===== hdl/y2r_if.sv =====
// ----------------------------------------------------------------------------
// y2r_if: valid/ready stream channels
// One channel for input blocks, one for RGB result items.
// ----------------------------------------------------------------------------
interface y2r_in_if import y2r_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface y2r_out_if import y2r_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/y2r_chroma.sv =====
// ----------------------------------------------------------------------------
// y2r_chroma: chroma weighting
// Clamps U and V, removes the chroma offset and forms the red, green and
// blue chroma terms shared by one 2x2 block.
// ----------------------------------------------------------------------------
module y2r_chroma import y2r_pkg::*; (
  input  sample_t       chroma_blue_i,
  input  sample_t       chroma_red_i,
  output chroma_terms_t terms_o
);

  localparam sum_t KRedV   = SUM_W'(RED_FROM_V);
  localparam sum_t KGreenU = SUM_W'(GREEN_FROM_U);
  localparam sum_t KGreenV = SUM_W'(GREEN_FROM_V);
  localparam sum_t KBlueU  = SUM_W'(BLUE_FROM_U);
  localparam sum_t KZero   = SUM_W'(CHROMA_ZERO);

  sum_t d;
  sum_t e;

  assign d = sum_t'({{(SUM_W-SAMPLE_W){1'b0}}, clamp_level(chroma_blue_i)}) - KZero;
  assign e = sum_t'({{(SUM_W-SAMPLE_W){1'b0}}, clamp_level(chroma_red_i)}) - KZero;

  assign terms_o.red   = KRedV * e;
  assign terms_o.green = '0 - KGreenU * d - KGreenV * e;
  assign terms_o.blue  = KBlueU * d;

endmodule

// ===== hdl/y2r_pixel.sv =====
// ----------------------------------------------------------------------------
// y2r_pixel: one pixel of the block
// Scales the clamped luma, adds the shared chroma terms and saturates
// each sum to a byte.
// ----------------------------------------------------------------------------
module y2r_pixel import y2r_pkg::*; (
  input  sample_t       luma_i,
  input  chroma_terms_t terms_i,
  output rgb_t          rgb_o
);

  sample_t                luma_off;
  logic [LUMA_TERM_W-1:0] luma_term;
  sum_t                   c;

  assign luma_off  = clamp_level(luma_i) - SAMPLE_W'(LEVEL_LOW);
  assign luma_term = LUMA_TERM_W'(LUMA_GAIN) * LUMA_TERM_W'(luma_off);
  assign c         = sum_t'({{(SUM_W-LUMA_TERM_W){1'b0}}, luma_term});

  assign rgb_o.red   = saturate_byte(c + terms_i.red);
  assign rgb_o.green = saturate_byte(c + terms_i.green);
  assign rgb_o.blue  = saturate_byte(c + terms_i.blue);

endmodule

// ===== hdl/yuv420_to_rgb24_block.sv =====
// Accepted items pass the input register, then the result register, which drives the output.
// Throughput: one 2x2 block per cycle; while a result waits at the output the input
// register takes one more item, then ready drops until the result drains.
// Conversion logic sits between the two registers: four luma scalers and
// one chroma weighting unit feeding twelve saturating adders.
// Reset (rst_ni low, asynchronous): both stages empty, no result pending.
// ----------------------------------------------------------------------------
// yuv420_to_rgb24_block: YUV 4:2:0 block to RGB24 converter
// Converts one 2x2 block of luma with shared U/V into twelve RGB bytes.
// ----------------------------------------------------------------------------
module yuv420_to_rgb24_block import y2r_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  y2r_in_if.sink   src_i,
  y2r_out_if.source dst_o
);

  logic          in_valid_q;
  in_item_t      in_data_q;
  logic          out_valid_q;
  out_item_t     out_data_q;
  out_item_t     out_data_d;
  logic          advance;
  logic          accept;
  chroma_terms_t terms;
  rgb_t          px_tl;
  rgb_t          px_tr;
  rgb_t          px_bl;
  rgb_t          px_br;

  // Move the input stage forward when the result register is free or drains
  assign advance     = !out_valid_q || dst_o.ready;
  assign src_i.ready = !in_valid_q || advance;
  assign accept      = src_i.valid && src_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (src_i.ready) begin
        in_valid_q <= src_i.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_data_q <= src_i.data;
    end
    if (advance && in_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  y2r_chroma u_chroma (
    .chroma_blue_i (in_data_q.chroma_blue),
    .chroma_red_i  (in_data_q.chroma_red),
    .terms_o       (terms)
  );

  y2r_pixel u_px_tl (.luma_i(in_data_q.luma_top_left),     .terms_i(terms), .rgb_o(px_tl));
  y2r_pixel u_px_tr (.luma_i(in_data_q.luma_top_right),    .terms_i(terms), .rgb_o(px_tr));
  y2r_pixel u_px_bl (.luma_i(in_data_q.luma_bottom_left),  .terms_i(terms), .rgb_o(px_bl));
  y2r_pixel u_px_br (.luma_i(in_data_q.luma_bottom_right), .terms_i(terms), .rgb_o(px_br));

  always_comb begin
    out_data_d.red_top_left       = px_tl.red;
    out_data_d.green_top_left     = px_tl.green;
    out_data_d.blue_top_left      = px_tl.blue;
    out_data_d.red_top_right      = px_tr.red;
    out_data_d.green_top_right    = px_tr.green;
    out_data_d.blue_top_right     = px_tr.blue;
    out_data_d.red_bottom_left    = px_bl.red;
    out_data_d.green_bottom_left  = px_bl.green;
    out_data_d.blue_bottom_left   = px_bl.blue;
    out_data_d.red_bottom_right   = px_br.red;
    out_data_d.green_bottom_right = px_br.green;
    out_data_d.blue_bottom_right  = px_br.blue;
  end

  assign dst_o.valid = out_valid_q;
  assign dst_o.data  = out_data_q;

  a_accept_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_valid_q)
    else $error("accepted item did not reach the input stage");

  a_advance_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && advance |=> out_valid_q)
    else $error("input stage advanced without producing a result");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_data_q))
    else $error("input stage lost its item during a stall");

  a_no_accept_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |-> !src_i.ready)
    else $error("ready raised while both stages are held");

endmodule

// ===== tb/rgb_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_result_checker: result predictor and comparator for the YUV to RGB block
// Watches both channels. Every accepted 2x2 block is converted here into its
// twelve expected RGB bytes. Every accepted result is matched byte by byte
// against the oldest expected item.
// ----------------------------------------------------------------------------
module rgb_result_checker import y2r_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  y2r_in_if         blk_i,
  y2r_out_if        rgb_i,
  output int        mismatch_cnt_o,
  output int        pending_o,
  output int        checked_o
);

  localparam int SHOWN_MAX = 10;

  out_item_t rgb_expected[$];

  string byte_name[12] = '{
    "red_top_left", "green_top_left", "blue_top_left",
    "red_top_right", "green_top_right", "blue_top_right",
    "red_bottom_left", "green_bottom_left", "blue_bottom_left",
    "red_bottom_right", "green_bottom_right", "blue_bottom_right"
  };

  // Pin a sample into the studio range 16..240
  function automatic int studio_level(sample_t v);
    int x;
    x = int'(v);
    if (x < LEVEL_LOW) begin
      x = LEVEL_LOW;
    end else if (x > LEVEL_HIGH) begin
      x = LEVEL_HIGH;
    end
    return x;
  endfunction

  // Drop the 8 fraction bits, then clip to one byte
  function automatic sample_t clip_byte(int s);
    sample_t r;
    if (s < 0) begin
      r = 8'h00;
    end else if (s >= SUM_LIMIT) begin
      r = 8'hff;
    end else begin
      r = sample_t'(s >>> FRAC_BITS);
    end
    return r;
  endfunction

  function automatic out_item_t predict_rgb(in_item_t b);
    sample_t          lumas[4];
    logic [3:0][23:0] px;
    int               u_off;
    int               v_off;
    int               red_add;
    int               green_add;
    int               blue_add;
    int               luma_base;
    lumas[0] = b.luma_top_left;
    lumas[1] = b.luma_top_right;
    lumas[2] = b.luma_bottom_left;
    lumas[3] = b.luma_bottom_right;
    u_off     = studio_level(b.chroma_blue) - CHROMA_ZERO;
    v_off     = studio_level(b.chroma_red) - CHROMA_ZERO;
    red_add   = RED_FROM_V * v_off;
    green_add = -GREEN_FROM_U * u_off - GREEN_FROM_V * v_off;
    blue_add  = BLUE_FROM_U * u_off;
    for (int k = 0; k < 4; k++) begin
      luma_base = LUMA_GAIN * (studio_level(lumas[k]) - LEVEL_LOW);
      // top left pixel sits in the upper bits
      px[3-k] = {clip_byte(luma_base + red_add),
                 clip_byte(luma_base + green_add),
                 clip_byte(luma_base + blue_add)};
    end
    return out_item_t'(px);
  endfunction

  initial begin
    mismatch_cnt_o = 0;
    pending_o      = 0;
    checked_o      = 0;
  end

  always @(posedge clk_i) begin : watch
    out_item_t want;
    logic [95:0] want_bits;
    logic [95:0] got_bits;
    if (rst_ni) begin
      // retire the result first: it is always older than a block taken now
      if (rgb_i.valid && rgb_i.ready) begin
        if (rgb_expected.size() == 0) begin
          if (mismatch_cnt_o < SHOWN_MAX) begin
            $display("unexpected result item at %0t: %h", $realtime, rgb_i.data);
          end
          mismatch_cnt_o = mismatch_cnt_o + 1;
        end else begin
          want      = rgb_expected.pop_front();
          want_bits = want;
          got_bits  = rgb_i.data;
          for (int i = 0; i < 12; i++) begin
            if (got_bits[95-8*i -: 8] !== want_bits[95-8*i -: 8]) begin
              if (mismatch_cnt_o < SHOWN_MAX) begin
                $display("item %0d %s: expected %0d, got %0d", checked_o, byte_name[i],
                         want_bits[95-8*i -: 8], got_bits[95-8*i -: 8]);
              end
              mismatch_cnt_o = mismatch_cnt_o + 1;
            end
          end
          checked_o = checked_o + 1;
        end
      end
      if (blk_i.valid && blk_i.ready) begin
        rgb_expected.push_back(predict_rgb(blk_i.data));
      end
      pending_o = rgb_expected.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the YUV 4:2:0 to RGB24 block
// Sends directed corner blocks, then random blocks with no idling at first, later with idle gaps
// on both channels and one long output hold-off. Checking is left to the checker.
// ----------------------------------------------------------------------------
module tb import y2r_pkg::*; ();

  localparam int RANDOM_BLOCKS = 1100;
  localparam int QUIET_BLOCKS  = 300;
  localparam int HOLD_AT       = 600;
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 20;
  localparam int IDLE_PCT      = 20;

  logic clk_i;
  logic rst_ni;

  bit gaps_on;
  bit hold_req;
  bit held_once;
  int sent_cnt;
  int mismatch_cnt;
  int pending_cnt;
  int checked_cnt;

  y2r_in_if  blk_ch ();
  y2r_out_if rgb_ch ();

  yuv420_to_rgb24_block dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .src_i  (blk_ch),
    .dst_o  (rgb_ch)
  );

  rgb_result_checker rgb_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .blk_i          (blk_ch),
    .rgb_i          (rgb_ch),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt),
    .checked_o      (checked_cnt)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic in_item_t make_block(int ytl, int ytr, int ybl, int ybr, int u, int v);
    in_item_t b;
    b.luma_top_left     = sample_t'(ytl);
    b.luma_top_right    = sample_t'(ytr);
    b.luma_bottom_left  = sample_t'(ybl);
    b.luma_bottom_right = sample_t'(ybr);
    b.chroma_blue       = sample_t'(u);
    b.chroma_red        = sample_t'(v);
    return b;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic offer_block(input in_item_t b);
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      blk_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    blk_ch.valid = 1'b1;
    blk_ch.data  = b;
    @(posedge clk_i);
    while (!blk_ch.ready) @(posedge clk_i);
    sent_cnt = sent_cnt + 1;
    @(negedge clk_i);
  endtask

  // Result side: random stalls, and one long hold-off on request
  initial begin
    rgb_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        rgb_ch.ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_req  = 1'b0;
        held_once = 1'b1;
      end else begin
        rgb_ch.ready = !(gaps_on && $urandom_range(99) < IDLE_PCT);
      end
    end
  end

  initial begin
    #500_000;
    $display("timeout: %0d results still outstanding", pending_cnt);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int mode;
    int s[6];
    int rim_vals[8];
    rim_vals     = '{0, 15, 16, 17, 239, 240, 241, 255};
    rst_ni       = 1'b0;
    blk_ch.valid = 1'b0;
    blk_ch.data  = '0;
    gaps_on      = 1'b1;
    hold_req     = 1'b0;
    held_once    = 1'b0;
    sent_cnt     = 0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed corners: range limits, clamps, both saturation sides
    offer_block(make_block(0, 0, 0, 0, 0, 0));
    offer_block(make_block(255, 255, 255, 255, 255, 255));
    offer_block(make_block(15, 16, 240, 241, 128, 128));
    offer_block(make_block(0, 1, 254, 255, 128, 128));
    offer_block(make_block(128, 128, 128, 128, 0, 0));
    offer_block(make_block(128, 128, 128, 128, 255, 255));
    offer_block(make_block(16, 100, 200, 240, 16, 240));
    offer_block(make_block(16, 100, 200, 240, 240, 16));
    offer_block(make_block(60, 120, 180, 235, 15, 241));
    offer_block(make_block(60, 120, 180, 235, 17, 239));
    offer_block(make_block(16, 16, 16, 16, 16, 16));
    offer_block(make_block(240, 240, 240, 240, 240, 240));
    offer_block(make_block(16, 235, 16, 235, 128, 128));
    offer_block(make_block(8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa));
    offer_block(make_block(8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55));
    offer_block(make_block(126, 127, 129, 130, 127, 129));

    // Random blocks: first a stretch with no idling, then gaps and a hold-off
    gaps_on = 1'b0;
    for (int n = 0; n < RANDOM_BLOCKS; n++) begin
      if (n == QUIET_BLOCKS) gaps_on = 1'b1;
      if (n == HOLD_AT) hold_req = 1'b1;
      mode = $urandom_range(99);
      for (int f = 0; f < 6; f++) begin
        if (mode < 40) begin
          s[f] = $urandom_range(255);
        end else if (mode < 80) begin
          s[f] = $urandom_range(LEVEL_HIGH, LEVEL_LOW);
        end else begin
          s[f] = rim_vals[$urandom_range(7)];
        end
      end
      offer_block(make_block(s[0], s[1], s[2], s[3], s[4], s[5]));
    end
    blk_ch.valid = 1'b0;

    while (pending_cnt != 0 || hold_req) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("covered %0d blocks in (directed corners, random, clamp edges), %0d results compared",
             sent_cnt, checked_cnt);
    $display("idle gaps on both channels, output hold-off of %0d cycles done: %0d",
             HOLD_CYCLES, held_once);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/y2r_pkg.sv
hdl/y2r_if.sv
hdl/y2r_chroma.sv
hdl/y2r_pixel.sv
hdl/yuv420_to_rgb24_block.sv
tb/rgb_result_checker.sv
tb/tb.sv
